FILE: hdl/dnsarp_pkg.sv
// Shared types and constants for the DNS response A-record parser.
package dnsarp_pkg;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_QLEN,
		PH_QLABEL,
		PH_QPTR,
		PH_QFIXED,
		PH_ALEN,
		PH_ALABEL,
		PH_APTR,
		PH_AFIXED,
		PH_RDATA,
		PH_DONE,
		PH_ERROR
	} phase_t;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_ID         = 4'd1;
	localparam logic [3:0] ST_NOT_RESP   = 4'd2;
	localparam logic [3:0] ST_OPCODE     = 4'd3;
	localparam logic [3:0] ST_QDCOUNT    = 4'd9;
	localparam logic [3:0] ST_LENGTH     = 4'd10;

	localparam logic       KIND_ADDR     = 1'b0;
	localparam logic       KIND_STATUS   = 1'b1;

	localparam logic [7:0] QR_MASK       = 8'h80;
	localparam logic [7:0] OPCODE_MASK   = 8'h78;
	localparam logic [7:0] RCODE_MASK    = 8'h0F;
	localparam logic [7:0] PTR_MASK      = 8'hC0;

	localparam logic [15:0] TYPE_A       = 16'd1;
	localparam logic [15:0] RDLEN_A      = 16'd4;

	// One request from the parser to the result side.
	typedef struct packed {
		logic        has_addr;
		logic [31:0] addr;
		logic [15:0] index;
		logic        has_status;
		logic [3:0]  status;
		logic [15:0] count;
	} job_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] addr;
		logic [15:0] index;
		logic [3:0]  status;
		logic [15:0] count;
		logic        last;
	} result_t;

endpackage

FILE: hdl/dnsarp_front.sv
// Byte parser: header checks, name skipping, answer walk; emits result requests.
module dnsarp_front import dnsarp_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  resp_byte,
	input  logic        end_of_message,
	input  logic [15:0] expected_id,
	output logic        push,
	output job_t        job
);

	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);

	phase_t            phase_q, phase_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [3:0]        fc_q, fc_n;
	logic [15:0]       ans_q, ans_n;
	logic [7:0]        lbl_q, lbl_n;
	logic [15:0]       rtype_q, rtype_n;
	logic [15:0]       rlen_q, rlen_n;
	logic [31:0]       acc_q, acc_n;
	logic [15:0]       found_q, found_n;
	logic [3:0]        err_q, err_n;
	logic              addr_hit;
	logic [3:0]        rc;
	logic [3:0]        st;

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		fc_n     = fc_q;
		ans_n    = ans_q;
		lbl_n    = lbl_q;
		rtype_n  = rtype_q;
		rlen_n   = rlen_q;
		acc_n    = acc_q;
		found_n  = found_q;
		err_n    = err_q;
		addr_hit = 1'b0;
		rc       = resp_byte[3:0] & RCODE_MASK[3:0];
		st       = ST_OK;

		if (phase_q != PH_ERROR) begin
			if (pos_q >= POS_MAX) begin
				err_n   = ST_LENGTH;
				phase_n = PH_ERROR;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						acc_n = {16'd0, acc_q[7:0], resp_byte};
						if (pos_q == POS_W'(1) && acc_n[15:0] != expected_id) begin
							err_n   = ST_ID;
							phase_n = PH_ERROR;
						end else if (pos_q == POS_W'(2)) begin
							if ((resp_byte & QR_MASK) == 8'd0) begin
								err_n   = ST_NOT_RESP;
								phase_n = PH_ERROR;
							end else if ((resp_byte & OPCODE_MASK) != 8'd0) begin
								err_n   = ST_OPCODE;
								phase_n = PH_ERROR;
							end
						end else if (pos_q == POS_W'(3)) begin
							if (rc inside {[4'd1:4'd5]}) begin
								err_n   = ST_OPCODE + rc;
								phase_n = PH_ERROR;
							end
						end else if (pos_q == POS_W'(5) && acc_n[15:0] != 16'd1) begin
							err_n   = ST_QDCOUNT;
							phase_n = PH_ERROR;
						end else if (pos_q == POS_W'(7)) begin
							ans_n = acc_n[15:0];
						end else if (pos_q == POS_W'(11)) begin
							acc_n   = 32'd0;
							phase_n = PH_QLEN;
						end
					end
					PH_QLEN, PH_ALEN: begin
						if (resp_byte == 8'd0) begin
							fc_n = 4'd0;
							if (phase_q == PH_QLEN) begin
								phase_n = PH_QFIXED;
							end else begin
								phase_n = PH_AFIXED;
								rtype_n = 16'd0;
								rlen_n  = 16'd0;
							end
						end else if ((resp_byte & PTR_MASK) != 8'd0) begin
							phase_n = (phase_q == PH_QLEN) ? PH_QPTR : PH_APTR;
						end else begin
							lbl_n   = resp_byte;
							phase_n = (phase_q == PH_QLEN) ? PH_QLABEL : PH_ALABEL;
						end
					end
					PH_QLABEL, PH_ALABEL: begin
						lbl_n = lbl_q - 8'd1;
						if (lbl_n == 8'd0)
							phase_n = (phase_q == PH_QLABEL) ? PH_QLEN : PH_ALEN;
					end
					PH_QPTR: begin
						fc_n    = 4'd0;
						phase_n = PH_QFIXED;
					end
					PH_APTR: begin
						fc_n    = 4'd0;
						phase_n = PH_AFIXED;
						rtype_n = 16'd0;
						rlen_n  = 16'd0;
					end
					PH_QFIXED: begin
						fc_n = fc_q + 4'd1;
						if (fc_n == 4'd4)
							phase_n = (ans_q == 16'd0) ? PH_DONE : PH_ALEN;
					end
					PH_AFIXED: begin
						if (fc_q < 4'd2)
							rtype_n = {rtype_q[7:0], resp_byte};
						else if (fc_q >= 4'd8)
							rlen_n = {rlen_q[7:0], resp_byte};
						fc_n = fc_q + 4'd1;
						if (fc_n == 4'd10) begin
							if (!(rtype_n == TYPE_A && rlen_n == RDLEN_A))
								rtype_n = 16'd0;
							acc_n = 32'd0;
							if (rlen_n == 16'd0) begin
								ans_n   = ans_q - 16'd1;
								phase_n = (ans_n == 16'd0) ? PH_DONE : PH_ALEN;
							end else begin
								phase_n = PH_RDATA;
							end
						end
					end
					PH_RDATA: begin
						acc_n  = {acc_q[23:0], resp_byte};
						rlen_n = rlen_q - 16'd1;
						if (rlen_n == 16'd0) begin
							ans_n    = ans_q - 16'd1;
							phase_n  = (ans_n == 16'd0) ? PH_DONE : PH_ALEN;
							addr_hit = (rtype_q == TYPE_A);
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (pos_q < POS_MAX)
			pos_n = pos_q + POS_W'(1);

		if (addr_hit && found_q != 16'hFFFF)
			found_n = found_q + 16'd1;

		if (phase_n == PH_ERROR)
			st = err_n;
		else if (phase_n == PH_DONE)
			st = ST_OK;
		else
			st = ST_LENGTH;

		job.has_addr   = addr_hit;
		job.addr       = acc_n;
		job.index      = found_q;
		job.has_status = end_of_message;
		job.status     = st;
		job.count      = found_n;
		push           = fire && (addr_hit || end_of_message);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			fc_q    <= '0;
			ans_q   <= '0;
			lbl_q   <= '0;
			rtype_q <= '0;
			rlen_q  <= '0;
			acc_q   <= '0;
			found_q <= '0;
			err_q   <= ST_OK;
		end else if (fire) begin
			if (end_of_message) begin
				phase_q <= PH_HEADER;
				pos_q   <= '0;
				fc_q    <= '0;
				ans_q   <= '0;
				lbl_q   <= '0;
				rtype_q <= '0;
				rlen_q  <= '0;
				acc_q   <= '0;
				found_q <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				fc_q    <= fc_n;
				ans_q   <= ans_n;
				lbl_q   <= lbl_n;
				rtype_q <= rtype_n;
				rlen_q  <= rlen_n;
				acc_q   <= acc_n;
				found_q <= found_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

FILE: hdl/dnsarp_fifo.sv
// Small flip-flop queue of result requests between parser and output side.
module dnsarp_fifo import dnsarp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == CNT_W'(0));
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

FILE: hdl/dnsarp_back.sv
// Result side: splits each request into address and status results, output register.
module dnsarp_back import dnsarp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    head,
	input  logic    empty,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    out_valid_q;
	result_t out_q;
	logic    addr_done_q;
	logic    take_addr;
	logic    load;
	result_t piece;

	always_comb begin
		take_addr = head.has_addr && !addr_done_q;
		if (take_addr) begin
			piece.kind   = KIND_ADDR;
			piece.addr   = head.addr;
			piece.index  = head.index;
			piece.status = ST_OK;
			piece.count  = 16'd0;
			piece.last   = !head.has_status;
		end else begin
			piece.kind   = KIND_STATUS;
			piece.addr   = 32'd0;
			piece.index  = 16'd0;
			piece.status = head.status;
			piece.count  = head.count;
			piece.last   = 1'b1;
		end
		load = !empty && (!out_valid_q || out_ready);
		pop  = load && !(take_addr && head.has_status);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			addr_done_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				addr_done_q <= take_addr && head.has_status;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= piece;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	a_split_pending: assert property (@(posedge clk) disable iff (!arst_n)
		addr_done_q |-> (!empty && head.has_addr && head.has_status))
		else $error("split request lost from queue head");

	a_split_holds_addr: assert property (@(posedge clk) disable iff (!arst_n)
		addr_done_q |-> (out_valid_q && out_q.kind == KIND_ADDR && !out_q.last))
		else $error("address half of split request not on output");

endmodule

FILE: hdl/dns_response_a_record_parser_unit.sv
// Top level of the DNS response A-record parser.
// Takes one response byte per clock (s_tlast marks the final byte) and checks the
// header, skips the question and walks the answers; each type A answer with a
// 4-byte RDATA yields an address result and the final byte yields a status result.
// The parser takes a byte every cycle; results leave one per cycle while m_tready is
// high, from an output register fed by a 4-entry request queue, so s_tready drops
// only while that queue is full. A final address-completing byte gives two results.
// expected_id is written over the cfg channel, which is always ready.
module dns_response_a_record_parser_unit import dnsarp_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,     // expected_id
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // resp_byte
	input  logic        s_tlast,      // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,      // ipv4_address, address_index, status, address_count
	output logic        m_tuser,      // result_kind
	output logic        m_tlast       // last
);

	logic [15:0] expected_id_q;
	logic        fire;
	logic        push;
	job_t        job;
	job_t        head;
	logic        empty;
	logic        full;
	logic        pop;
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			expected_id_q <= 16'd1;
		else if (cfg_valid && cfg_ready)
			expected_id_q <= cfg_data;
	end

	assign s_tready = !full;
	assign fire     = s_tvalid && s_tready;

	dnsarp_front #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.resp_byte     (s_tdata),
		.end_of_message(s_tlast),
		.expected_id   (expected_id_q),
		.push          (push),
		.job           (job)
	);

	dnsarp_fifo #(
		.DEPTH(4)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(job),
		.pop   (pop),
		.head  (head),
		.empty (empty),
		.full  (full)
	);

	dnsarp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {4'd0, res.count, res.status, res.index, res.addr};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule
